// File: src/rgba_cmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_cmp_pkg
// Shared types, codes and control store of the rgba compositing core.
// ----------------------------------------------------------------------------
package rgba_cmp_pkg;

    localparam int NUM_CH   = 4;
    localparam int CH_IDX_W = 2;
    localparam int QSCALE_W = 17;
    localparam int LEVEL_W  = 16;
    localparam int CMD_W    = 2;
    localparam int UADDR_W  = 3;

    localparam logic [CH_IDX_W-1:0] CH_ALPHA = 2'd3;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OVER  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNDER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BLEND = 2'd3;

    // multiplier a operand
    localparam logic [1:0] A_KEPT     = 2'd0;
    localparam logic [1:0] A_SRC      = 2'd1;
    localparam logic [1:0] A_INV_KEPT = 2'd2;

    // multiplier b operand
    localparam logic [1:0] B_WA      = 2'd0;
    localparam logic [1:0] B_WB      = 2'd1;
    localparam logic [1:0] B_INV_SRC = 2'd2;
    localparam logic [1:0] B_SCALE   = 2'd3;

    // writeback
    localparam logic [1:0] WB_NONE  = 2'd0;
    localparam logic [1:0] WB_SAT   = 2'd1;
    localparam logic [1:0] WB_INV   = 2'd2;
    localparam logic [1:0] WB_QUANT = 2'd3;

    // jump conditions
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_ALPHA    = 3'd2;
    localparam logic [2:0] JC_NOT_LAST = 3'd3;
    localparam logic [2:0] JC_OUT_BUSY = 3'd4;

    // control store addresses
    localparam logic [UADDR_W-1:0] UA_MIX_A   = 3'd0;
    localparam logic [UADDR_W-1:0] UA_MIX_B   = 3'd1;
    localparam logic [UADDR_W-1:0] UA_MIX_WB  = 3'd2;
    localparam logic [UADDR_W-1:0] UA_QNT_MUL = 3'd3;
    localparam logic [UADDR_W-1:0] UA_QNT_WB  = 3'd4;
    localparam logic [UADDR_W-1:0] UA_EMIT    = 3'd5;
    localparam logic [UADDR_W-1:0] UA_ALP_MUL = 3'd6;
    localparam logic [UADDR_W-1:0] UA_ALP_WB  = 3'd7;

    typedef struct packed {
        logic [1:0]         a_sel;
        logic [1:0]         b_sel;
        logic               acc_clr;
        logic [1:0]         wb_sel;
        logic               ch_inc;
        logic [2:0]         cond;
        logic [UADDR_W-1:0] target;
        logic               emit;
    } uword_t;

    function automatic uword_t ucode(input logic [UADDR_W-1:0] addr);
        uword_t w;
        w = '{a_sel: A_KEPT, b_sel: B_WA, acc_clr: 1'b0, wb_sel: WB_NONE,
              ch_inc: 1'b0, cond: JC_NONE, target: UA_MIX_A, emit: 1'b0};
        unique case (addr)
            UA_MIX_A: begin
                w.a_sel = A_KEPT;  w.b_sel = B_WA;  w.acc_clr = 1'b1;
                w.cond = JC_ALPHA; w.target = UA_ALP_MUL;
            end
            UA_MIX_B: begin
                w.a_sel = A_SRC;   w.b_sel = B_WB;
            end
            UA_MIX_WB: begin
                w.wb_sel = WB_SAT; w.ch_inc = 1'b1;
                w.cond = JC_NOT_LAST; w.target = UA_MIX_A;
            end
            UA_QNT_MUL: begin
                w.a_sel = A_KEPT;  w.b_sel = B_SCALE; w.acc_clr = 1'b1;
            end
            UA_QNT_WB: begin
                w.wb_sel = WB_QUANT; w.ch_inc = 1'b1;
                w.cond = JC_NOT_LAST; w.target = UA_QNT_MUL;
            end
            UA_EMIT: begin
                w.cond = JC_OUT_BUSY; w.target = UA_EMIT; w.emit = 1'b1;
            end
            UA_ALP_MUL: begin
                w.a_sel = A_INV_KEPT; w.b_sel = B_INV_SRC; w.acc_clr = 1'b1;
            end
            UA_ALP_WB: begin
                w.wb_sel = WB_INV; w.ch_inc = 1'b1;
                w.cond = JC_ALWAYS; w.target = UA_QNT_MUL;
            end
            default: begin
                w.cond = JC_ALWAYS; w.target = UA_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: src/rgba_compositing_accumulator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_compositing_accumulator_core
// Keeps one rgba color and composites source words into it (load, over,
// under, weighted blend), then returns the color quantized to levels.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_cmd, s_src_*, s_*_weight
//  m_        out        m_valid / m_ready   m_*_level
//  apb       in         psel/penable/pready quant_scale @0x0, level_cap @0x4
//
//  a word runs through 12 mix steps, 8 quantize steps and one emit step,
//  and stays in the emit step while the result register is full; all
//  multiplies go through one shared mac unit driven by an 8-step
//  control store
//  s_ready is high whenever no word is in progress and reset is released,
//  also while a result waits
//  reset (aresetn low, synchronous) clears the color to zero and loads the
//  register defaults
// ----------------------------------------------------------------------------
module rgba_compositing_accumulator_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_cmd,
    input  wire logic [FRAC_BITS:0]     s_src_red,
    input  wire logic [FRAC_BITS:0]     s_src_green,
    input  wire logic [FRAC_BITS:0]     s_src_blue,
    input  wire logic [FRAC_BITS:0]     s_src_alpha,
    input  wire logic [FRAC_BITS+1:0]   s_local_weight,
    input  wire logic [FRAC_BITS+1:0]   s_source_weight,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [15:0]                 m_red_level,
    output logic [15:0]                 m_green_level,
    output logic [15:0]                 m_blue_level,
    output logic [15:0]                 m_alpha_level,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CH_W  = FRAC_BITS + 1;
    localparam int WT_W  = FRAC_BITS + 2;
    localparam int QS_W  = rgba_cmp_pkg::QSCALE_W;
    localparam int LV_W  = rgba_cmp_pkg::LEVEL_W;
    localparam int IX_W  = rgba_cmp_pkg::CH_IDX_W;
    localparam int B_W   = (WT_W > QS_W) ? WT_W : QS_W;
    localparam int P_W   = CH_W + B_W;
    localparam int ACC_W = P_W + 1;
    localparam int SH_W  = ACC_W - FRAC_BITS;

    localparam logic [CH_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // registers
    logic [QS_W-1:0]                  quant_scale_reg;
    logic [LV_W-1:0]                  level_cap_reg;
    logic [CH_W-1:0]                  kept_reg [rgba_cmp_pkg::NUM_CH];
    logic [CH_W-1:0]                  src_reg  [rgba_cmp_pkg::NUM_CH];
    logic [LV_W-1:0]                  lvl_reg  [rgba_cmp_pkg::NUM_CH];
    logic [WT_W-1:0]                  lw_reg, sw_reg;
    logic [rgba_cmp_pkg::CMD_W-1:0]   cmd_reg;
    logic [ACC_W-1:0]                 acc_reg, acc_next;
    logic [rgba_cmp_pkg::UADDR_W-1:0] upc_reg, upc_next;
    logic [IX_W-1:0]                  ch_reg, ch_next;
    logic                             busy_reg, busy_next;
    logic                             m_valid_reg, m_valid_next;
    logic [LV_W-1:0]                  m_lvl_reg [rgba_cmp_pkg::NUM_CH];

    rgba_cmp_pkg::uword_t uw;
    logic             take, jump, emit_now, cfg_wr;
    logic [CH_W-1:0]  a_op;
    logic [B_W-1:0]   b_op;
    logic [P_W-1:0]   prod;
    logic [WT_W-1:0]  wa, wb;
    logic [SH_W-1:0]  acc_sh;
    logic [CH_W-1:0]  sat_val, inv_val;
    logic [LV_W-1:0]  qnt_val;

    function automatic logic [CH_W-1:0] clamp_one(input logic [CH_W-1:0] x);
        return (x > ONE) ? ONE : x;
    endfunction

    assign s_ready  = aresetn && !busy_reg;
    assign take     = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_red_level   = m_lvl_reg[0];
    assign m_green_level = m_lvl_reg[1];
    assign m_blue_level  = m_lvl_reg[2];
    assign m_alpha_level = m_lvl_reg[3];

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {{(32-LV_W){1'b0}}, level_cap_reg}
                             : {{(32-QS_W){1'b0}}, quant_scale_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_scale_reg <= QS_W'(256);
            level_cap_reg   <= LV_W'(255);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                level_cap_reg <= pwdata[LV_W-1:0];
            end else begin
                quant_scale_reg <= pwdata[QS_W-1:0];
            end
        end
    end

    // control word
    assign uw = rgba_cmp_pkg::ucode(upc_reg);

    // blend weights per command
    always_comb begin
        case (cmd_reg)
            rgba_cmp_pkg::CMD_LOAD: begin
                wa = '0;
                wb = WT_W'(ONE);
            end
            rgba_cmp_pkg::CMD_OVER: begin
                wa = WT_W'(ONE - src_reg[rgba_cmp_pkg::CH_ALPHA]);
                wb = WT_W'(src_reg[rgba_cmp_pkg::CH_ALPHA]);
            end
            rgba_cmp_pkg::CMD_UNDER: begin
                wa = WT_W'(kept_reg[rgba_cmp_pkg::CH_ALPHA]);
                wb = WT_W'(ONE - kept_reg[rgba_cmp_pkg::CH_ALPHA]);
            end
            default: begin
                wa = lw_reg;
                wb = sw_reg;
            end
        endcase
    end

    // mac datapath
    always_comb begin
        case (uw.a_sel)
            rgba_cmp_pkg::A_SRC:      a_op = src_reg[ch_reg];
            rgba_cmp_pkg::A_INV_KEPT: a_op = ONE - kept_reg[rgba_cmp_pkg::CH_ALPHA];
            default:                  a_op = kept_reg[ch_reg];
        endcase
        case (uw.b_sel)
            rgba_cmp_pkg::B_WA:      b_op = B_W'(wa);
            rgba_cmp_pkg::B_WB:      b_op = B_W'(wb);
            rgba_cmp_pkg::B_INV_SRC: b_op = B_W'(ONE - src_reg[rgba_cmp_pkg::CH_ALPHA]);
            default:                 b_op = B_W'(quant_scale_reg);
        endcase
        prod     = P_W'(a_op) * P_W'(b_op);
        acc_next = (uw.acc_clr ? '0 : acc_reg) + ACC_W'(prod);
    end

    // writeback values
    assign acc_sh  = acc_reg[ACC_W-1:FRAC_BITS];
    assign sat_val = (acc_sh > SH_W'(ONE)) ? ONE : acc_sh[CH_W-1:0];
    assign inv_val = ONE - acc_sh[CH_W-1:0];
    assign qnt_val = (acc_sh > SH_W'(level_cap_reg)) ? level_cap_reg : acc_sh[LV_W-1:0];

    // sequencer
    always_comb begin
        unique case (uw.cond)
            rgba_cmp_pkg::JC_ALWAYS:   jump = 1'b1;
            rgba_cmp_pkg::JC_ALPHA:    jump = (ch_reg == rgba_cmp_pkg::CH_ALPHA) &&
                                              (cmd_reg == rgba_cmp_pkg::CMD_OVER ||
                                               cmd_reg == rgba_cmp_pkg::CMD_UNDER);
            rgba_cmp_pkg::JC_NOT_LAST: jump = (ch_reg != rgba_cmp_pkg::CH_ALPHA);
            rgba_cmp_pkg::JC_OUT_BUSY: jump = m_valid_reg && !m_ready;
            default:                   jump = 1'b0;
        endcase
        emit_now     = busy_reg && uw.emit && !jump;
        busy_next    = busy_reg;
        upc_next     = upc_reg;
        ch_next      = ch_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            busy_next = 1'b1;
            upc_next  = rgba_cmp_pkg::UA_MIX_A;
            ch_next   = '0;
        end else if (busy_reg) begin
            upc_next = jump ? uw.target : upc_reg + 1'b1;
            if (uw.ch_inc) begin
                ch_next = ch_reg + 1'b1;
            end
            if (emit_now) begin
                busy_next    = 1'b0;
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            upc_reg     <= rgba_cmp_pkg::UA_MIX_A;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < rgba_cmp_pkg::NUM_CH; i++) begin
                kept_reg[i] <= '0;
            end
        end else begin
            busy_reg    <= busy_next;
            upc_reg     <= upc_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
            if (busy_reg) begin
                case (uw.wb_sel)
                    rgba_cmp_pkg::WB_SAT: kept_reg[ch_reg] <= sat_val;
                    rgba_cmp_pkg::WB_INV: kept_reg[ch_reg] <= inv_val;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg    <= s_cmd;
            src_reg[0] <= clamp_one(s_src_red);
            src_reg[1] <= clamp_one(s_src_green);
            src_reg[2] <= clamp_one(s_src_blue);
            src_reg[3] <= clamp_one(s_src_alpha);
            lw_reg     <= s_local_weight;
            sw_reg     <= s_source_weight;
        end
        if (busy_reg) begin
            acc_reg <= acc_next;
            if (uw.wb_sel == rgba_cmp_pkg::WB_QUANT) begin
                lvl_reg[ch_reg] <= qnt_val;
            end
        end
        if (emit_now) begin
            for (int i = 0; i < rgba_cmp_pkg::NUM_CH; i++) begin
                m_lvl_reg[i] <= lvl_reg[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // a new word starts at the top of the program on channel zero
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (upc_reg == rgba_cmp_pkg::UA_MIX_A) && (ch_reg == '0) && !s_ready)
        else $error("word did not start at program entry");

    // a result appears only out of the emit step
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(upc_reg) == rgba_cmp_pkg::UA_EMIT)
        else $error("result raised outside emit step");

    // kept color stays within zero to one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (kept_reg[0] <= ONE) && (kept_reg[1] <= ONE) &&
        (kept_reg[2] <= ONE) && (kept_reg[3] <= ONE))
        else $error("kept channel above one");

    // the sequencer leaves the emit step only by finishing the word
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && upc_reg == rgba_cmp_pkg::UA_EMIT && !(m_valid_reg && !m_ready))
        |=> !busy_reg && m_valid_reg)
        else $error("emit step did not complete word");
`endif

endmodule
`default_nettype wire
